// ----- hw/rtl/flow_tuple_hash_unit_defines.svh -----
// Assertion macros shared by the flow tuple hash RTL.
// All macros sample on clock and are disabled while reset is high.
`ifndef FLOW_TUPLE_HASH_UNIT_DEFINES_SVH
`define FLOW_TUPLE_HASH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FTUH_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked a fixed number of cycles later.
`define FTUH_ASSERT_DELAY(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/ftuh_pkg.sv -----
`default_nettype none

package ftuh_pkg;

   // 0xdeadbeef plus the packed key length in bytes
   localparam logic [31:0] SeedBase = 32'hdeadbeef;
   localparam logic [31:0] KeyBytes = 32'd13;
   localparam logic [31:0] SeedInit = SeedBase + KeyBytes;

   localparam int unsigned RspBucketWidth = 16;

   typedef enum logic [1:0] {
      STAGE_MIX_LO,
      STAGE_MIX_HI,
      STAGE_FIN_LO,
      STAGE_FIN_HI
   } stage_kind_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [7:0]  protocol;
   } pipe_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
      rotl = (x << k) | (x >> (32 - k));
   endfunction

   // One pipeline stage worth of the mix and final rounds.
   function automatic pipe_type stage_fn(input stage_kind_type kind, input pipe_type d);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      pipe_type    r;
      a = d.a;
      b = d.b;
      c = d.c;
      case (kind)
         STAGE_MIX_LO: begin
            a = a - c; a = a ^ rotl(c, 4); c = c + b;
            b = b - a; b = b ^ rotl(a, 6); a = a + c;
            c = c - b; c = c ^ rotl(b, 8); b = b + a;
         end
         STAGE_MIX_HI: begin
            a = a - c; a = a ^ rotl(c, 16); c = c + b;
            b = b - a; b = b ^ rotl(a, 19); a = a + c;
            c = c - b; c = c ^ rotl(b, 4);  b = b + a;
            // protocol folds in between mix and final rounds
            a = a + {24'd0, d.protocol};
         end
         STAGE_FIN_LO: begin
            c = c ^ b; c = c - rotl(b, 14);
            a = a ^ c; a = a - rotl(c, 11);
            b = b ^ a; b = b - rotl(a, 25);
            c = c ^ b; c = c - rotl(b, 16);
         end
         STAGE_FIN_HI: begin
            a = a ^ c; a = a - rotl(c, 4);
            b = b ^ a; b = b - rotl(a, 14);
            c = c ^ b; c = c - rotl(b, 24);
         end
         default: begin
         end
      endcase
      r.a        = a;
      r.b        = b;
      r.c        = c;
      r.protocol = d.protocol;
      stage_fn   = r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ftuh_stage.sv -----
`default_nettype none

module ftuh_stage
   import ftuh_pkg::*;
#(
   parameter stage_kind_type KIND = STAGE_MIX_LO
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire pipe_type in_data,
   output logic          out_valid,
   output pipe_type      out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   always_comb begin
      data_in = stage_fn(KIND, in_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/flow_tuple_hash_unit.sv -----
`default_nettype none
`include "flow_tuple_hash_unit_defines.svh"
// Flow 5-tuple hash unit (lookup3-style mix and final rounds).
//
// Request channel: drive req_* and pulse start; a transaction is taken at a
// rising edge where start is high and busy is low. busy is only high during
// reset, so a new tuple can be issued every cycle.
// Response channel: rsp_valid is high for exactly one cycle per transaction,
// with rsp_hash_value (final word c) and rsp_bucket (low BUCKET_BITS of the
// hash, limited to 16 bits). Responses come out in request order.
// Path: rsp_valid is driven by the fin_hi stage register; a transaction passes
// the seed, mix_lo, mix_hi, fin_lo and fin_hi registers in that order.
// Throughput: 1 tuple per cycle, set by the five-stage pipeline (seed add,
// two mix half-rounds, two final half-rounds), each stage a registered chain
// of 32-bit add, subtract and xor steps (a single add in the seed stage).
// Reset: synchronous; clears all stage valid bits, dropping any transaction
// in flight. No state is kept between tuples.
// The receiver cannot stall: a response is gone after its strobe cycle.

module flow_tuple_hash_unit
   import ftuh_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [15:0] req_src_port_num,
   input  wire logic [15:0] req_dst_port_num,
   output logic             rsp_valid,
   output logic [31:0]      rsp_hash_value,
   output logic [15:0]      rsp_bucket
);

   localparam logic [31:0] BucketMask = 32'hFFFF_FFFF >> (32 - BUCKET_BITS);

   logic     accept;
   logic     seed_valid_ff;
   pipe_type seed_ff;
   pipe_type seed_in;

   logic     mix_lo_valid;
   pipe_type mix_lo_data;
   logic     mix_hi_valid;
   pipe_type mix_hi_data;
   logic     fin_lo_valid;
   pipe_type fin_lo_data;
   logic     fin_hi_valid;
   pipe_type fin_hi_data;
   logic [31:0] bucket_full;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      seed_in.a        = SeedInit + req_src_addr;
      seed_in.b        = SeedInit + req_dst_addr;
      seed_in.c        = SeedInit + {req_src_port_num, req_dst_port_num};
      seed_in.protocol = req_protocol;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_valid_ff <= 1'b0;
      end else begin
         seed_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
   end

   ftuh_stage #(.KIND(STAGE_MIX_LO)) u_mix_lo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seed_valid_ff),
      .in_data   (seed_ff),
      .out_valid (mix_lo_valid),
      .out_data  (mix_lo_data)
   );

   ftuh_stage #(.KIND(STAGE_MIX_HI)) u_mix_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_lo_valid),
      .in_data   (mix_lo_data),
      .out_valid (mix_hi_valid),
      .out_data  (mix_hi_data)
   );

   ftuh_stage #(.KIND(STAGE_FIN_LO)) u_fin_lo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_hi_valid),
      .in_data   (mix_hi_data),
      .out_valid (fin_lo_valid),
      .out_data  (fin_lo_data)
   );

   ftuh_stage #(.KIND(STAGE_FIN_HI)) u_fin_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fin_lo_valid),
      .in_data   (fin_lo_data),
      .out_valid (fin_hi_valid),
      .out_data  (fin_hi_data)
   );

   assign bucket_full    = fin_hi_data.c & BucketMask;
   assign rsp_valid      = fin_hi_valid;
   assign rsp_hash_value = fin_hi_data.c;
   assign rsp_bucket     = bucket_full[RspBucketWidth-1:0];

   // every accepted transaction shows up after passing the seed, mix and final stage registers
   `FTUH_ASSERT_DELAY(a_req_to_rsp, accept, 5, rsp_valid)
   // no response without a matching accepted transaction earlier
   `FTUH_ASSERT_IMPL(a_rsp_has_req, rsp_valid, $past(accept, 5))
   // pipeline can only fill from the seed stage
   `FTUH_ASSERT_IMPL(a_mix_from_seed, mix_lo_valid, $past(seed_valid_ff))

endmodule

`default_nettype wire
